[src/chd_pkg.sv]
// shared constants, register codes and sine table math for the stereo chorus
package chd_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int BEAT_W     = 2 * SAMPLE_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int BASE_W     = 15;
    localparam int DEPTH_W    = 16;
    localparam int PHASE_W    = 32;
    localparam int GAIN_W     = 16;

    localparam int DEF_RING_DEPTH   = 65536;
    localparam int DEF_SINE_ENTRIES = 256;

    // bit-serial multiplier operand widths
    localparam int MUL_AW = 32;
    localparam int MUL_BW = 16;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    // delay math: base << 31 plus modulation plus half
    localparam int DQ_W     = 49;
    localparam int DQ_SHIFT = 31;

    // mix accumulator and rounding shift
    localparam int ACC_W     = 36;
    localparam int MIX_SHIFT = 16;

    localparam longint SIN_A = 102944;
    localparam longint SIN_B = 42334;
    localparam longint SIN_C = 4926;
    localparam longint SIN_ONE = 65536;
    localparam longint SIN_CAP = 32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BASE_DELAY = 3'd0,
        CFG_MOD_DEPTH  = 3'd1,
        CFG_LFO_STEP   = 3'd2,
        CFG_WET_GAIN   = 3'd3,
        CFG_DRY_GAIN   = 3'd4
    } cfg_reg_t;

    // q1.15 sine from quadrant and q16 position inside the quadrant
    function automatic logic signed [SAMPLE_W-1:0] sine_entry(input logic [1:0] quad,
                                                              input logic [16:0] pos);
        longint x;
        longint x2;
        longint t;
        longint mag;
        x   = quad[0] ? (SIN_ONE - longint'(pos)) : longint'(pos);
        x2  = (x * x) >> 16;
        t   = (SIN_C * x2) >> 16;
        t   = SIN_B - t;
        t   = (t * x2) >> 16;
        t   = SIN_A - t;
        mag = ((t * x) >> 16) >> 1;
        if (mag > SIN_CAP) begin
            mag = SIN_CAP;
        end
        return quad[1] ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
    endfunction

endpackage

[src/chd_smul.sv]
// bit-serial shift-add multiplier, signed a times unsigned b, one bit of b per cycle
module chd_smul #(
    parameter int AW = chd_pkg::MUL_AW,
    parameter int BW = chd_pkg::MUL_BW
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [AW-1:0] a,
    input  logic [BW-1:0]        b,
    output logic                 done,
    output logic signed [AW+BW-1:0] p
);

    localparam int CW = (BW > 1) ? $clog2(BW) : 1;
    localparam logic [CW-1:0] LAST_STEP = CW'(BW - 1);

    logic signed [AW-1:0] mcand_reg;
    logic signed [AW:0]   hi_reg;
    logic [BW-1:0]        lo_reg;
    logic [CW-1:0]        cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic signed [AW:0]   sum;

    // partial product into the upper half, then shift the pair right
    assign sum = hi_reg + (lo_reg[0] ? {mcand_reg[AW-1], mcand_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= LAST_STEP;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            mcand_reg <= a;
            hi_reg    <= '0;
            lo_reg    <= b;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[AW], sum[AW:1]};
            lo_reg <= {sum[0], lo_reg[BW-1:1]};
        end
    end

    assign done = done_reg;
    assign p    = {hi_reg[AW-1:0], lo_reg};

endmodule

[src/chd_sine.sv]
// lfo sine lookup: phase to table index, registered table read
module chd_sine #(
    parameter int SINE_ENTRIES = chd_pkg::DEF_SINE_ENTRIES
) (
    input  logic                                clk,
    input  logic [chd_pkg::PHASE_W-1:0]         phase,
    output logic signed [chd_pkg::SAMPLE_W-1:0] sine
);
    import chd_pkg::*;

    localparam int KW = $clog2(SINE_ENTRIES);
    localparam int MW = PHASE_W + KW + 1;

    logic signed [SAMPLE_W-1:0] sine_tab [SINE_ENTRIES];
    logic [MW-1:0]              scaled;
    logic [KW-1:0]              k_reg;
    logic signed [SAMPLE_W-1:0] sine_reg;

    for (genvar i = 0; i < SINE_ENTRIES; i++)
    begin : g_tab
        localparam longint K4  = 4 * i;
        localparam longint QD  = K4 / SINE_ENTRIES;
        localparam longint REM = K4 - QD * SINE_ENTRIES;
        localparam longint POS = (REM * 65536) / SINE_ENTRIES;
        assign sine_tab[i] = sine_entry(2'(QD), 17'(POS));
    end

    // index is the top of phase times the table size
    assign scaled = MW'(phase) * MW'(SINE_ENTRIES);

    always_ff @(posedge clk)
    begin
        k_reg    <= scaled[PHASE_W +: KW];
        sine_reg <= sine_tab[k_reg];
    end

    assign sine = sine_reg;

endmodule

[src/chd_ring.sv]
// stereo delay ring memory with a zeroing sweep after reset
module chd_ring #(
    parameter int RING_DEPTH = chd_pkg::DEF_RING_DEPTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               we,
    input  logic [$clog2(RING_DEPTH)-1:0]      waddr,
    input  logic [chd_pkg::BEAT_W-1:0]         wdata,
    input  logic [$clog2(RING_DEPTH)-1:0]      raddr,
    output logic [chd_pkg::BEAT_W-1:0]         rdata,
    output logic                               clearing
);
    import chd_pkg::*;

    localparam int PW = $clog2(RING_DEPTH);
    localparam logic [PW-1:0] LAST_ADDR = PW'(RING_DEPTH - 1);

    logic [BEAT_W-1:0] mem [RING_DEPTH];
    logic [PW-1:0]     clr_addr_reg;
    logic              clr_busy_reg;
    logic              wr_en;
    logic [PW-1:0]     wr_addr;
    logic [BEAT_W-1:0] wr_data;
    logic [BEAT_W-1:0] rdata_reg;

    always_comb
    begin
        wr_en   = clr_busy_reg | we;
        wr_addr = clr_busy_reg ? clr_addr_reg : waddr;
        wr_data = clr_busy_reg ? '0 : wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata    = rdata_reg;
    assign clearing = clr_busy_reg;

endmodule

[src/stereo_chorus_delay.sv]
// stereo chorus top level: control sequencer, config registers and datapath
//
// Input beats arrive on s_axis (tdata = in_left low, in_right high), one stereo
// pair per beat; output beats leave on m_axis with the same packing. Config
// registers are written through cfg_we / cfg_index / cfg_wdata, by the user
// only while idle (the block itself does not enforce this): index 0 base_delay,
// 1 mod_depth, 2 lfo_step, 3 wet_gain, 4 dry_gain. After reset the delay rings
// are zeroed by a sweep over all RING_DEPTH addresses (65536 by default);
// s_axis_tready stays low until it ends, config writes are taken throughout.
// Each pair runs through six 16-step bit-serial multiplies in one shared
// multiplier (base times depth, that times the lfo sine, then wet and dry
// terms for each channel) plus eight other steps. s_axis_tready is high only
// in the idle state, so the next input beat is taken only once the pair
// before it has been loaded into the output register. If m_axis_tready is
// low, the next pair is still accepted and computed, and it waits for the
// register to empty before it is loaded.
module stereo_chorus_delay #(
    parameter int RING_DEPTH   = chd_pkg::DEF_RING_DEPTH,
    parameter int SINE_ENTRIES = chd_pkg::DEF_SINE_ENTRIES
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [chd_pkg::BEAT_W-1:0]        s_axis_tdata,  // in_left, in_right
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [chd_pkg::BEAT_W-1:0]        m_axis_tdata,  // out_left, out_right
    input  logic                              cfg_we,
    input  logic [chd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [chd_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
    import chd_pkg::*;

    localparam int PW    = $clog2(RING_DEPTH);
    localparam int DSH_W = DQ_W - 1 - DQ_SHIFT;
    localparam int DW    = (PW > DSH_W) ? PW : DSH_W;
    localparam logic [DW-1:0]   D_MAX     = DW'(RING_DEPTH - 1);
    localparam logic [PW-1:0]   LAST_ADDR = PW'(RING_DEPTH - 1);
    localparam logic [PW-1:0]   DEPTH_MOD = PW'(RING_DEPTH);
    localparam logic [DQ_W-1:0] DQ_ROUND  = DQ_W'(1) << (DQ_SHIFT - 1);
    localparam logic [ACC_W-1:0] MIX_ROUND = ACC_W'(1) << (MIX_SHIFT - 1);
    localparam int GUARD_LO = MIX_SHIFT + SAMPLE_W - 1;
    localparam logic signed [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef enum logic [15:0] {
        ST_CLEAR = 16'b0000_0000_0000_0001,
        ST_IDLE  = 16'b0000_0000_0000_0010,
        ST_MBD   = 16'b0000_0000_0000_0100,
        ST_MVAR  = 16'b0000_0000_0000_1000,
        ST_DQ    = 16'b0000_0000_0001_0000,
        ST_DLY   = 16'b0000_0000_0010_0000,
        ST_WR    = 16'b0000_0000_0100_0000,
        ST_RD    = 16'b0000_0000_1000_0000,
        ST_RWAIT = 16'b0000_0001_0000_0000,
        ST_MLW   = 16'b0000_0010_0000_0000,
        ST_MLD   = 16'b0000_0100_0000_0000,
        ST_LSAT  = 16'b0000_1000_0000_0000,
        ST_MRW   = 16'b0001_0000_0000_0000,
        ST_MRD   = 16'b0010_0000_0000_0000,
        ST_RSAT  = 16'b0100_0000_0000_0000,
        ST_OUT   = 16'b1000_0000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    logic [BASE_W-1:0]  base_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic [PHASE_W-1:0] step_reg;
    logic [GAIN_W-1:0]  wet_reg;
    logic [GAIN_W-1:0]  dry_reg;
    logic [PHASE_W-1:0] phase_reg;
    logic [PW-1:0]      wp_reg;
    logic               mul_start_reg;
    logic               out_valid_reg;
    logic [BEAT_W-1:0]  out_data_reg;

    logic signed [SAMPLE_W-1:0] in_l_reg;
    logic signed [SAMPLE_W-1:0] in_r_reg;
    logic signed [SAMPLE_W-1:0] del_l_reg;
    logic signed [SAMPLE_W-1:0] del_r_reg;
    logic                       sin_neg_reg;
    logic [SAMPLE_W-2:0]        sin_mag_reg;
    logic signed [MUL_AW-1:0]   prod_reg;
    logic signed [MUL_PW-1:0]   mod_reg;
    logic signed [DQ_W-1:0]     dq_reg;
    logic [PW-1:0]              d_reg;
    logic [PW-1:0]              rd_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic signed [SAMPLE_W-1:0] res_l_reg;
    logic signed [SAMPLE_W-1:0] res_r_reg;

    logic                       in_fire;
    logic                       out_load;
    logic                       mul_state_next;
    logic signed [SAMPLE_W-1:0] sine;
    logic signed [SAMPLE_W-1:0] sine_abs;
    logic                       clearing;
    logic [BEAT_W-1:0]          ring_rdata;
    logic                       mul_done;
    logic signed [MUL_AW-1:0]   mul_a;
    logic [MUL_BW-1:0]          mul_b;
    logic signed [MUL_PW-1:0]   mul_p;
    logic signed [SAMPLE_W:0]   sum_l;
    logic signed [SAMPLE_W:0]   sum_r;
    logic [DSH_W-1:0]           dsh;
    logic [DW-1:0]              d_ext;
    logic [DW-1:0]              d_clamp;
    logic [PW:0]                rd_diff;
    logic [PW-1:0]              rd_wrap;
    logic [PW-1:0]              wp_inc;

    function automatic logic signed [SAMPLE_W-1:0] saturate(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-GUARD_LO-1:0] guard;
        guard = acc[ACC_W-1:GUARD_LO];
        if (!acc[ACC_W-1] && (guard != '0))
        begin
            return SAT_MAX;
        end
        else if (acc[ACC_W-1] && (guard != '1))
        begin
            return SAT_MIN;
        end
        return acc[GUARD_LO:MIX_SHIFT];
    endfunction

    chd_sine #(
        .SINE_ENTRIES(SINE_ENTRIES)
    ) u_sine (
        .clk  (clk),
        .phase(phase_reg),
        .sine (sine)
    );

    chd_ring #(
        .RING_DEPTH(RING_DEPTH)
    ) u_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (state_reg == ST_WR),
        .waddr   (wp_reg),
        .wdata   ({in_r_reg, in_l_reg}),
        .raddr   (rd_reg),
        .rdata   (ring_rdata),
        .clearing(clearing)
    );

    chd_smul #(
        .AW(MUL_AW),
        .BW(MUL_BW)
    ) u_mul (
        .clk  (clk),
        .rst_n(rst_n),
        .start(mul_start_reg),
        .a    (mul_a),
        .b    (mul_b),
        .done (mul_done),
        .p    (mul_p)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == ST_OUT) && (!out_valid_reg || m_axis_tready);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // sine pipeline runs freely; it has settled long before the next beat
    assign sine_abs = sine[SAMPLE_W-1] ? -sine : sine;

    assign sum_l = {in_l_reg[SAMPLE_W-1], in_l_reg} + {del_l_reg[SAMPLE_W-1], del_l_reg};
    assign sum_r = {in_r_reg[SAMPLE_W-1], in_r_reg} + {del_r_reg[SAMPLE_W-1], del_r_reg};

    // delay in samples, clamped to the ring
    assign dsh     = dq_reg[DQ_W-2:DQ_SHIFT];
    assign d_ext   = DW'(dsh);
    assign d_clamp = dq_reg[DQ_W-1] ? '0 : ((d_ext > D_MAX) ? D_MAX : d_ext);

    assign rd_diff = {1'b0, wp_reg} - {1'b0, d_reg};
    assign rd_wrap = rd_diff[PW] ? (rd_diff[PW-1:0] + DEPTH_MOD) : rd_diff[PW-1:0];
    assign wp_inc  = (wp_reg == LAST_ADDR) ? '0 : (wp_reg + 1'b1);

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MBD:
            begin
                mul_a = {{(MUL_AW-BASE_W){1'b0}}, base_reg};
                mul_b = depth_reg;
            end
            ST_MVAR:
            begin
                mul_a = sin_neg_reg ? -prod_reg : prod_reg;
                mul_b = {{(MUL_BW-SAMPLE_W+1){1'b0}}, sin_mag_reg};
            end
            ST_MLW:
            begin
                mul_a = {{(MUL_AW-SAMPLE_W-1){sum_l[SAMPLE_W]}}, sum_l};
                mul_b = wet_reg;
            end
            ST_MLD:
            begin
                mul_a = {{(MUL_AW-SAMPLE_W){in_l_reg[SAMPLE_W-1]}}, in_l_reg};
                mul_b = dry_reg;
            end
            ST_MRW:
            begin
                mul_a = {{(MUL_AW-SAMPLE_W-1){sum_r[SAMPLE_W]}}, sum_r};
                mul_b = wet_reg;
            end
            ST_MRD:
            begin
                mul_a = {{(MUL_AW-SAMPLE_W){in_r_reg[SAMPLE_W-1]}}, in_r_reg};
                mul_b = dry_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (!clearing) state_next = ST_IDLE;
            ST_IDLE:  if (in_fire) state_next = ST_MBD;
            ST_MBD:   if (mul_done) state_next = ST_MVAR;
            ST_MVAR:  if (mul_done) state_next = ST_DQ;
            ST_DQ:    state_next = ST_DLY;
            ST_DLY:   state_next = ST_WR;
            ST_WR:    state_next = ST_RD;
            ST_RD:    state_next = ST_RWAIT;
            ST_RWAIT: state_next = ST_MLW;
            ST_MLW:   if (mul_done) state_next = ST_MLD;
            ST_MLD:   if (mul_done) state_next = ST_LSAT;
            ST_LSAT:  state_next = ST_MRW;
            ST_MRW:   if (mul_done) state_next = ST_MRD;
            ST_MRD:   if (mul_done) state_next = ST_RSAT;
            ST_RSAT:  state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    // kick the multiplier once on entry to each multiply state
    assign mul_state_next = (state_next != state_reg) &&
                            ((state_next == ST_MBD) || (state_next == ST_MVAR) ||
                             (state_next == ST_MLW) || (state_next == ST_MLD) ||
                             (state_next == ST_MRW) || (state_next == ST_MRD));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            mul_start_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= '0;
            wp_reg        <= '0;
            base_reg      <= '0;
            depth_reg     <= '0;
            step_reg      <= '0;
            wet_reg       <= '0;
            dry_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_start_reg <= mul_state_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (in_fire)
            begin
                phase_reg <= phase_reg + step_reg;
            end
            if (state_reg == ST_DLY)
            begin
                wp_reg <= wp_inc;
            end
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BASE_DELAY: base_reg  <= cfg_wdata[BASE_W-1:0];
                    CFG_MOD_DEPTH:  depth_reg <= cfg_wdata[DEPTH_W-1:0];
                    CFG_LFO_STEP:   step_reg  <= cfg_wdata[PHASE_W-1:0];
                    CFG_WET_GAIN:   wet_reg   <= cfg_wdata[GAIN_W-1:0];
                    CFG_DRY_GAIN:   dry_reg   <= cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            in_l_reg    <= s_axis_tdata[SAMPLE_W-1:0];
            in_r_reg    <= s_axis_tdata[BEAT_W-1:SAMPLE_W];
            sin_neg_reg <= sine[SAMPLE_W-1];
            sin_mag_reg <= sine_abs[SAMPLE_W-2:0];
        end
        if ((state_reg == ST_MBD) && mul_done)
        begin
            prod_reg <= mul_p[MUL_AW-1:0];
        end
        if ((state_reg == ST_MVAR) && mul_done)
        begin
            mod_reg <= mul_p;
        end
        if (state_reg == ST_DQ)
        begin
            dq_reg <= {{(DQ_W-BASE_W-DQ_SHIFT){1'b0}}, base_reg, {DQ_SHIFT{1'b0}}}
                    + {{(DQ_W-MUL_PW){mod_reg[MUL_PW-1]}}, mod_reg} + DQ_ROUND;
        end
        if (state_reg == ST_DLY)
        begin
            d_reg <= d_clamp[PW-1:0];
        end
        if (state_reg == ST_WR)
        begin
            rd_reg <= rd_wrap;
        end
        if (state_reg == ST_RWAIT)
        begin
            del_l_reg <= ring_rdata[SAMPLE_W-1:0];
            del_r_reg <= ring_rdata[BEAT_W-1:SAMPLE_W];
        end
        if (((state_reg == ST_MLW) || (state_reg == ST_MRW)) && mul_done)
        begin
            acc_reg <= mul_p[ACC_W-1:0];
        end
        if (((state_reg == ST_MLD) || (state_reg == ST_MRD)) && mul_done)
        begin
            // dry term counts twice, plus half an lsb for rounding
            acc_reg <= acc_reg + {mul_p[ACC_W-2:0], 1'b0} + MIX_ROUND;
        end
        if (state_reg == ST_LSAT)
        begin
            res_l_reg <= saturate(acc_reg);
        end
        if (state_reg == ST_RSAT)
        begin
            res_r_reg <= saturate(acc_reg);
        end
        if (out_load)
        begin
            out_data_reg <= {res_r_reg, res_l_reg};
        end
    end

endmodule

[tb/chorus_scoreboard.sv]
// scoreboard for the stereo chorus: mirrors register writes, predicts each output pair, compares
`timescale 1ns / 100ps
module chorus_scoreboard (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    input  logic                           s_axis_tready,
    input  logic [chd_pkg::BEAT_W-1:0]     s_axis_tdata,   // in_left, in_right
    input  logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic [chd_pkg::BEAT_W-1:0]     m_axis_tdata,   // out_left, out_right
    input  logic                           cfg_we,
    input  logic [chd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [chd_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             errors,
    output int                             pending,
    output int                             checked
);
    import chd_pkg::*;

    localparam int     RING    = DEF_RING_DEPTH;
    localparam longint SINE_N  = DEF_SINE_ENTRIES;
    localparam int     REPORTS = 10;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] right;
        logic signed [SAMPLE_W-1:0] left;
    } stereo_t;

    logic signed [SAMPLE_W-1:0] left_hist [RING];
    logic signed [SAMPLE_W-1:0] right_hist [RING];
    int                         wr_pos;
    logic [PHASE_W-1:0]         phase;

    longint                     base_delay;
    longint                     mod_depth;
    logic [PHASE_W-1:0]         phase_step;
    longint                     wet_gain;
    longint                     dry_gain;

    stereo_t                    predicted_out [$];
    stereo_t                    want;
    stereo_t                    got;
    int                         mismatches;
    int                         pairs_checked;

    assign errors  = mismatches;
    assign checked = pairs_checked;

    // q1.15 sine picked from a coarse table index, odd quadrants mirrored
    function automatic longint lfo_sine(input logic [PHASE_W-1:0] ph);
        longint unsigned k;
        longint unsigned quad;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned t;
        longint unsigned mag;
        k    = ({32'd0, ph} * SINE_N) >> 32;
        quad = (k * 4) / SINE_N;
        x    = ((k * 4 - quad * SINE_N) * 65536) / SINE_N;
        if (quad[0])
        begin
            x = 65536 - x;
        end
        x2  = (x * x) >> 16;
        t   = (SIN_C * x2) >> 16;
        t   = SIN_B - t;
        t   = (t * x2) >> 16;
        t   = SIN_A - t;
        mag = ((t * x) >> 16) >> 1;
        if (mag > 32767)
        begin
            mag = 32767;
        end
        return quad[1] ? -longint'(mag) : longint'(mag);
    endfunction

    // dry plus delayed, times wet, plus twice dry times dry gain, rounded half up
    function automatic logic signed [SAMPLE_W-1:0] mix_sample(input longint smp, input longint dly);
        longint acc;
        longint r;
        acc = (smp + dly) * wet_gain + 2 * smp * dry_gain;
        r   = (acc + 32768) >>> 16;
        if (r > 32767)
        begin
            r = 32767;
        end
        if (r < -32768)
        begin
            r = -32768;
        end
        return r[SAMPLE_W-1:0];
    endfunction

    function automatic stereo_t chorus_pair(input logic signed [SAMPLE_W-1:0] l,
                                            input logic signed [SAMPLE_W-1:0] r);
        longint  dq;
        longint  dly;
        int      rd;
        stereo_t res;
        dq = (base_delay <<< 31) + base_delay * mod_depth * lfo_sine(phase) + (longint'(1) <<< 30);
        if (dq < 0)
        begin
            dq = 0;
        end
        dly = dq >>> 31;
        if (dly > RING - 1)
        begin
            dly = RING - 1;
        end
        // pointer moves first, then the write, so a zero delay reads the new pair
        wr_pos             = (wr_pos + 1) % RING;
        left_hist[wr_pos]  = l;
        right_hist[wr_pos] = r;
        rd                 = int'((wr_pos + RING - dly) % RING);
        res.left           = mix_sample(l, left_hist[rd]);
        res.right          = mix_sample(r, right_hist[rd]);
        phase              = phase + phase_step;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < RING; i++)
            begin
                left_hist[i]  = '0;
                right_hist[i] = '0;
            end
            wr_pos     = 0;
            phase      = '0;
            base_delay = 0;
            mod_depth  = 0;
            phase_step = '0;
            wet_gain   = 0;
            dry_gain   = 0;
            predicted_out.delete();
            mismatches    = 0;
            pairs_checked = 0;
            pending      <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_BASE_DELAY: base_delay = cfg_wdata[BASE_W-1:0];
                    CFG_MOD_DEPTH:  mod_depth  = cfg_wdata[DEPTH_W-1:0];
                    CFG_LFO_STEP:   phase_step = cfg_wdata[PHASE_W-1:0];
                    CFG_WET_GAIN:   wet_gain   = cfg_wdata[GAIN_W-1:0];
                    CFG_DRY_GAIN:   dry_gain   = cfg_wdata[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                predicted_out.push_back(chorus_pair(s_axis_tdata[SAMPLE_W-1:0],
                                                    s_axis_tdata[BEAT_W-1:SAMPLE_W]));
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (predicted_out.size() == 0)
                begin
                    if (mismatches < REPORTS)
                    begin
                        $display("output beat with no pair outstanding: L=%0d R=%0d",
                                 got.left, got.right);
                    end
                    mismatches++;
                end
                else
                begin
                    want = predicted_out.pop_front();
                    if (got.left !== want.left || got.right !== want.right)
                    begin
                        if (mismatches < REPORTS)
                        begin
                            $display("mismatch on pair %0d: expected L=%0d R=%0d, got L=%0d R=%0d",
                                     pairs_checked, want.left, want.right, got.left, got.right);
                        end
                        mismatches++;
                    end
                    pairs_checked++;
                end
            end
            pending <= predicted_out.size();
        end
    end

endmodule

[tb/testbench.sv]
// top of the stereo chorus testbench: clock, reset, register programming and beat traffic
`timescale 1ns / 100ps
module testbench;
    import chd_pkg::*;

    localparam int LIMIT        = 1_000_000;
    localparam int LONG_HOLD    = 1500;
    localparam int RANDOM_PAIRS = 830;
    localparam int CALM_TAIL    = 120;
    localparam int SETTLE       = 150;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic [BEAT_W-1:0]     s_axis_tdata  = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [BEAT_W-1:0]     m_axis_tdata;

    int errors;
    int pending;
    int checked;
    int settings;
    bit hold_req;
    bit rx_quiet;
    bit calm;

    stereo_chorus_delay u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    chorus_scoreboard u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .errors        (errors),
        .pending       (pending),
        .checked       (checked)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d pairs still outstanding", cycles, pending);
        $display("testbench: errors");
        $finish;
    end

    // output side: random back-pressure, one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 1'b0;
                m_axis_tready <= 1'b1;
            end
            else if (!calm && !rx_quiet && $urandom_range(0, 7) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    // unused upper data bits carry junk; the block keeps only the register width
    task automatic program_regs(input logic [BASE_W-1:0] bd, input logic [DEPTH_W-1:0] md,
                                input logic [PHASE_W-1:0] step, input logic [GAIN_W-1:0] wet,
                                input logic [GAIN_W-1:0] dry);
        write_reg(CFG_BASE_DELAY, {17'($urandom()), bd});
        write_reg(CFG_MOD_DEPTH, {16'($urandom()), md});
        write_reg(CFG_LFO_STEP, step);
        write_reg(CFG_WET_GAIN, {16'($urandom()), wet});
        write_reg(CFG_DRY_GAIN, {16'($urandom()), dry});
        if ($urandom_range(0, 2) == 0)
        begin
            write_reg(CFG_IDX_W'(CFG_DRY_GAIN + 1 + $urandom_range(0, 2)), $urandom());
        end
        @(posedge clk);
        cfg_we <= 1'b0;
        settings++;
    endtask

    task automatic send_pair(input logic [SAMPLE_W-1:0] l, input logic [SAMPLE_W-1:0] r,
                             input bit idle);
        if (idle && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r, l};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return SAMPLE_W'($urandom_range(0, 64) - 32);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 16'h8000;
            2:       return 16'hFFFF;
            3:       return GAIN_W'($urandom_range(0, 65535));
            default: return GAIN_W'($urandom_range(0, 32768));
        endcase
    endfunction

    initial
    begin
        logic [BASE_W-1:0]  bd;
        logic [DEPTH_W-1:0] md;
        logic [PHASE_W-1:0] step;
        int                 sent;
        int                 n;
        int                 phase_no;
        bit                 tx_idle;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // zero delay, unity gains: output is twice the input, saturating
        program_regs(0, 0, 0, 16'h8000, 16'h8000);
        send_pair(16'h7FFF, 16'h8000, 1'b0);
        send_pair(16'h8000, 16'h7FFF, 1'b0);
        send_pair(16'h0000, 16'h0000, 1'b0);
        send_pair(16'hFFFF, 16'h0001, 1'b0);
        send_pair(16'h5555, 16'hAAAA, 1'b0);
        send_pair(16'hAAAA, 16'h5555, 1'b0);
        drain();

        // longest delay, full depth, quarter-turn steps through every quadrant, gains past unity
        program_regs(15'h7FFF, 16'hFFFF, 32'h4000_0000, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 6; i++)
        begin
            send_pair(pick_sample(), pick_sample(), 1'b1);
        end
        drain();

        // short delay reading back recent pairs
        program_regs(3, 16'h8000, 32'h0100_0000, 16'h4000, 16'h2000);
        for (int i = 0; i < 8; i++)
        begin
            send_pair(pick_sample(), pick_sample(), 1'b1);
        end
        drain();

        sent     = 0;
        phase_no = 0;
        while (sent < RANDOM_PAIRS)
        begin
            case ($urandom_range(0, 5))
                0:       bd = '0;
                1:       bd = 15'h7FFF;
                2, 3:    bd = BASE_W'($urandom_range(1, 40));
                4:       bd = BASE_W'($urandom_range(41, 2000));
                default: bd = BASE_W'($urandom_range(0, 32767));
            endcase
            case ($urandom_range(0, 3))
                0:       md = '0;
                1:       md = 16'hFFFF;
                default: md = DEPTH_W'($urandom_range(0, 65535));
            endcase
            case ($urandom_range(0, 4))
                0:       step = '0;
                1:       step = 32'hFFFF_FFFF;
                2:       step = PHASE_W'($urandom_range(1, 1 << 24));
                default: step = $urandom();
            endcase
            program_regs(bd, md, step, pick_gain(), pick_gain());

            calm     = (sent >= RANDOM_PAIRS - CALM_TAIL);
            rx_quiet = ($urandom_range(0, 3) == 0);
            tx_idle  = !calm && ($urandom_range(0, 3) != 0);
            // output held off while the input keeps offering, so the block backs up
            if (phase_no == 2)
            begin
                hold_req = 1'b1;
            end
            n = $urandom_range(15, 60);
            for (int i = 0; i < n; i++)
            begin
                send_pair(pick_sample(), pick_sample(), tx_idle);
            end
            sent += n;
            phase_no++;
            drain();
        end

        repeat (SETTLE) @(posedge clk);
        $display("summary: %0d stereo pairs checked over %0d register settings", checked, settings);
        $display("covered zero and longest delay, all sine quadrants, high gains, %0d-cycle stall",
                 LONG_HOLD);
        if (errors == 0 && pending == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule

[sim.f]
src/chd_pkg.sv
src/chd_smul.sv
src/chd_sine.sv
src/chd_ring.sv
src/stereo_chorus_delay.sv
tb/chorus_scoreboard.sv
tb/testbench.sv
